/* hdl/min_priority_queue_macros.svh */
// Assertion macros for the min-priority queue.
// Each expects clk and rst_n in scope at the point of use.
`ifndef MIN_PRIORITY_QUEUE_MACROS_SVH
`define MIN_PRIORITY_QUEUE_MACROS_SVH

// Check a condition at every clock edge out of reset.
`define MPQ_ASSERT_ALWAYS(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition on one edge brings a consequence on the next edge.
`define MPQ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/mpq_pkg.sv */
`timescale 1ns / 1ps

package mpq_pkg;

  localparam int CAPACITY_DEF      = 255;
  localparam int ELEMENT_WIDTH_DEF = 16;

  localparam int VALUE_W  = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 8;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_LOAD,
    S_DN_RD,
    S_DN_CMP,
    S_FIN
  } state_t;

endpackage

/* hdl/mpq_if.sv */
`timescale 1ns / 1ps

interface mpq_in_if;
  import mpq_pkg::*;

  logic                        valid;
  logic                        ready;
  op_t                         op;
  logic signed [VALUE_W-1:0]   value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface mpq_out_if;
  import mpq_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [VALUE_W-1:0]   min_value;
  status_t                     status;
  logic        [COUNT_W-1:0]   count;

  modport source (output valid, output min_value, output status, output count, input ready);
  modport sink   (input valid, input min_value, input status, input count, output ready);
endinterface

/* hdl/mpq_heap_mem.sv */
`timescale 1ns / 1ps

module mpq_heap_mem #(
  parameter int DEPTH = mpq_pkg::CAPACITY_DEF,
  parameter int AW    = 8,
  parameter int W     = mpq_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic [AW-1:0] rd_addr_a,
  input  logic [AW-1:0] rd_addr_b,
  output logic [W-1:0]  rd_data_a,
  output logic [W-1:0]  rd_data_b
);
  import mpq_pkg::*;

  logic [W-1:0] mem_r [DEPTH];
  logic [W-1:0] rd_a_r;
  logic [W-1:0] rd_b_r;

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_a_r <= mem_r[rd_addr_a];
    rd_b_r <= mem_r[rd_addr_b];
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

/* hdl/min_priority_queue.sv */
`timescale 1ns / 1ps
// Channel  | Role   | Payload
// in_ch    | sink   | op (insert / delete minimum), value
// out_ch   | source | min_value, status, count
//
// in_ch is ready again on the same edge that raises out_ch.valid. An insert climbs from the
// new leaf and a delete descends from the root, each by the read-compare-write heap loop;
// a full insert or an empty delete goes straight to the result.
// Reset (rst_n low, synchronous) empties the queue; the memory holds no reset state.
// Stalls: the next item is taken while a result waits on out_ch, then holds before completion.

module min_priority_queue #(
  parameter int CAPACITY      = mpq_pkg::CAPACITY_DEF,
  parameter int ELEMENT_WIDTH = mpq_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  mpq_in_if.sink    in_ch,
  mpq_out_if.source out_ch
);
  import mpq_pkg::*;

  `include "min_priority_queue_macros.svh"

  // count width holds CAPACITY itself; addresses only reach CAPACITY-1;
  // child indices need one more bit than the count
  localparam int W  = ELEMENT_WIDTH;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW = CW + 1;

  state_t        state_r,  state_nxt;
  logic [CW-1:0] count_r,  count_nxt;
  logic [AW-1:0] pos_r,    pos_nxt;
  logic [W-1:0]  val_r,    val_nxt;
  logic [W-1:0]  min_r,    min_nxt;
  status_t       status_r, status_nxt;

  logic                out_valid_r;
  logic [VALUE_W-1:0]  out_min_r;
  status_t             out_status_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic                out_load;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [W-1:0]  wr_data;
  logic [AW-1:0] rd_addr_a;
  logic [AW-1:0] rd_addr_b;
  logic [W-1:0]  rd_data_a;
  logic [W-1:0]  rd_data_b;

  logic [W-1:0]  in_val_ext;
  logic [AW-1:0] parent;
  logic [LW-1:0] left_idx;
  logic [LW-1:0] right_idx;
  logic          has_right;
  logic          pick_right;
  logic [W-1:0]  child_val;
  logic [AW-1:0] child_idx;

  function automatic logic lt(input logic [W-1:0] a, input logic [W-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

  mpq_heap_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .W     (W)
  ) u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  // Keep the item's bit pattern as it stands, cut or zero-padded to the element width;
  // ordering treats the top element bit as the sign.
  assign in_val_ext = W'($unsigned(in_ch.value));

  // Heap index arithmetic around the current hole position.
  assign parent    = AW'((pos_r - 1'b1) >> 1);
  assign left_idx  = LW'({pos_r, 1'b1});
  assign right_idx = left_idx + 1'b1;
  assign has_right = right_idx < LW'(count_r);

  // Pick the smaller child; the left one wins a tie or when the right one is absent.
  assign pick_right = has_right && lt(rd_data_b, rd_data_a);
  assign child_val  = pick_right ? rd_data_b : rd_data_a;
  assign child_idx  = pick_right ? AW'(right_idx) : AW'(left_idx);

  assign out_load    = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    val_r    <= val_nxt;
    min_r    <= min_nxt;
    status_r <= status_nxt;
  end

  // Result register: parts the heap engine from a stalled consumer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_min_r    <= VALUE_W'(min_r);
      out_status_r <= status_r;
      out_count_r  <= COUNT_W'(count_r);
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.min_value = out_min_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.count     = out_count_r;

  // Hole-based sifting: the moving value stays in val_r and is written once at the end;
  // each level reads in one cycle and compares and writes in the next, so a read whose
  // data is used never meets a write to the same entry in the same cycle.
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    min_nxt    = min_r;
    status_nxt = status_r;
    wr_en      = 1'b0;
    wr_addr    = pos_r;
    wr_data    = val_r;
    rd_addr_a  = '0;
    rd_addr_b  = '0;

    unique case (state_r)
      S_IDLE: begin
        // fetch the root and the last element ahead of a possible delete
        rd_addr_a = '0;
        rd_addr_b = AW'(count_r - 1'b1);
        if (in_ch.valid) begin
          min_nxt    = '0;
          status_nxt = ST_OK;
          if (in_ch.op == OP_INSERT) begin
            if (count_r >= CW'(CAPACITY)) begin
              status_nxt = ST_FULL;
              state_nxt  = S_FIN;
            end else begin
              val_nxt   = in_val_ext;
              pos_nxt   = AW'(count_r);
              count_nxt = count_r + 1'b1;
              state_nxt = S_UP_RD;
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_FIN;
            end else begin
              count_nxt = count_r - 1'b1;
              state_nxt = S_DN_LOAD;
            end
          end
        end
      end

      S_UP_RD: begin
        rd_addr_a = parent;
        if (pos_r == '0) begin
          wr_en     = 1'b1;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        wr_en = 1'b1;
        if (lt(val_r, rd_data_a)) begin
          // pull the parent down into the hole and climb
          wr_data   = rd_data_a;
          pos_nxt   = parent;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_DN_LOAD: begin
        // root is the minimum; the last element fills the hole at the root
        min_nxt   = rd_data_a;
        val_nxt   = rd_data_b;
        pos_nxt   = '0;
        state_nxt = (count_r == '0) ? S_FIN : S_DN_RD;
      end

      S_DN_RD: begin
        rd_addr_a = AW'(left_idx);
        rd_addr_b = AW'(right_idx);
        if (left_idx >= LW'(count_r)) begin
          wr_en     = 1'b1;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_DN_CMP;
        end
      end

      S_DN_CMP: begin
        wr_en = 1'b1;
        if (lt(child_val, val_r)) begin
          // lift the smaller child into the hole and descend
          wr_data   = child_val;
          pos_nxt   = child_idx;
          state_nxt = S_DN_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  `MPQ_ASSERT_ALWAYS(a_count_bound, count_r <= CW'(CAPACITY), "count exceeds capacity")
  `MPQ_ASSERT_ALWAYS(a_wr_in_range, !wr_en || (CW'(wr_addr) < count_r), "write beyond count")
  `MPQ_ASSERT_NEXT(a_insert_count,
    in_ch.valid && in_ch.ready && in_ch.op == OP_INSERT && count_r < CW'(CAPACITY),
    count_r == CW'($past(count_r) + 1'b1), "insert did not grow count")
  `MPQ_ASSERT_ALWAYS(a_empty_result,
    !(out_ch.valid && out_ch.status == ST_EMPTY) || (out_ch.count == '0 && out_ch.min_value == '0),
    "empty result with data")

endmodule
